/* rtl/bpc_pkg.sv */
// Shared types, constants and multiply helpers for the barometric compensation block.
// Used by every module of the block; depends on nothing.
package bpc_pkg;

  // Configuration port geometry: four 48-bit registers at 8-byte spacing.
  localparam int unsigned RegW     = 48;
  localparam int unsigned DataW    = 64;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DivSteps = 64;

  // Register indexes.
  localparam logic [1:0] RegCalTemp   = 2'd0;
  localparam logic [1:0] RegCalPressA = 2'd1;
  localparam logic [1:0] RegCalPressB = 2'd2;
  localparam logic [1:0] RegCalPressC = 2'd3;

  // Compensation constants.
  localparam logic signed [31:0] TfineOffset = 32'sd128000;
  localparam logic [20:0]        PressOne    = 21'd1048576;
  localparam logic [15:0]        PressScale  = 16'd3125;
  localparam logic signed [33:0] TempRound   = 34'sd128;
  localparam logic signed [33:0] TempMul     = 34'sd5;
  localparam logic [63:0]        PressBias   = 64'h0000_8000_0000_0000;

  // Input item and result item.
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic               press_valid;
  } out_t;

  // Trimming words unpacked from the four registers.
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Temperature section to coefficient section.
  typedef struct packed {
    logic signed [31:0] tfine;
    logic [19:0]        raw_press;
  } tf_t;

  // Coefficient section to divider: magnitudes and sign of the quotient.
  typedef struct packed {
    logic [63:0]        num;
    logic [30:0]        den;
    logic               qneg;
    logic               dz;
    logic signed [31:0] temp;
  } div_in_t;

  // Divider to final section.
  typedef struct packed {
    logic [63:0]        quo;
    logic               qneg;
    logic               dz;
    logic signed [31:0] temp;
  } div_out_t;

  // Low 64 bits of a 64-bit word times an unsigned 16-bit word.
  function automatic logic [63:0] mul_u64_u16(input logic [63:0] x, input logic [15:0] y);
    logic [79:0] pr;
    pr = {16'b0, x} * {64'b0, y};
    return pr[63:0];
  endfunction

  // Low 64 bits of a 64-bit word times a signed 16-bit word.
  function automatic logic [63:0] mul_u64_s16(input logic [63:0] x, input logic [15:0] y);
    logic [63:0] lo;
    logic [63:0] corr;
    lo   = mul_u64_u16(x, y);
    corr = y[15] ? {x[47:0], 16'b0} : 64'd0;
    return lo - corr;
  endfunction

endpackage

/* rtl/bpc_temp.sv */
// Temperature section: four pipeline stages from the raw reading to t_fine.
// Depends on bpc_pkg.
module bpc_temp import bpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  in_t  data_i,
  input  cal_t cal_i,
  output logic vld_o,
  output tf_t  data_o
);

  logic [3:0]         vld_q;
  logic signed [17:0] d1_q, d1_d;
  logic signed [16:0] d2_q, d2_d;
  logic signed [33:0] m1_q, m1_d, sq_q, sq_d;
  logic signed [22:0] tv1_q, tv1_d;
  logic signed [21:0] sqs;
  logic signed [37:0] m2_q, m2_d;
  logic signed [23:0] tv2;
  logic [19:0]        rp1_q, rp2_q, rp3_q;
  tf_t                out_q, out_d;

  // Differences of the raw reading against T1, then the products, then the sum.
  always_comb begin
    d1_d = $signed({1'b0, data_i.raw_temp[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
    d2_d = $signed({1'b0, data_i.raw_temp[19:4]}) - $signed({1'b0, cal_i.t1});
    m1_d = d1_q * cal_i.t2;
    sq_d = d2_q * d2_q;
    tv1_d = 23'(m1_q >>> 11);
    sqs  = 22'(sq_q >>> 12);
    m2_d = sqs * cal_i.t3;
    tv2  = 24'(m2_q >>> 14);
    out_d.tfine     = 32'(tv1_q) + 32'(tv2);
    out_d.raw_press = rp3_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q  <= d1_d;
      d2_q  <= d2_d;
      rp1_q <= data_i.raw_press;
      m1_q  <= m1_d;
      sq_q  <= sq_d;
      rp2_q <= rp1_q;
      tv1_q <= tv1_d;
      m2_q  <= m2_d;
      rp3_q <= rp2_q;
      out_q <= out_d;
    end
  end

  assign vld_o  = vld_q[3];
  assign data_o = out_q;

endmodule

/* rtl/bpc_coef.sv */
// Coefficient section: seven stages that form the dividend and divisor magnitudes.
// Depends on bpc_pkg.
module bpc_coef import bpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  tf_t     data_i,
  input  cal_t    cal_i,
  output logic    vld_o,
  output div_in_t data_o
);

  logic [6:0]         vld_q;
  // Stage 5
  logic signed [25:0] a_q;
  logic signed [33:0] tt;
  logic signed [31:0] temp5_q, temp5_d;
  logic [19:0]        rp5_q;
  // Stage 6
  logic signed [51:0] aa_q;
  logic signed [41:0] ap5_q, ap2_q;
  logic signed [31:0] temp6_q;
  logic [19:0]        rp6_q;
  // Stage 7
  logic [63:0]        bt1_q, aap3_q;
  logic signed [41:0] ap5_7_q, ap2_7_q;
  logic signed [31:0] temp7_q;
  logic [19:0]        rp7_q;
  // Stage 8
  logic [63:0]        b_q, b_d, a2_q, a2_d;
  logic signed [31:0] temp8_q;
  logic [19:0]        rp8_q;
  // Stage 9
  logic [63:0]        x_q, nb_q, nb_d;
  logic signed [31:0] temp9_q;
  // Stage 10
  logic [63:0]        prod_q, nm_q;
  logic signed [31:0] temp10_q;
  // Stage 11
  logic [30:0]        dv;
  div_in_t            out_q, out_d;

  // Scaled temperature with its rounding term, and the rounded temperature result.
  always_comb begin
    tt      = 34'(data_i.tfine) * TempMul + TempRound;
    temp5_d = 32'(tt >>> 8);
  end

  // Sums of the offset and dividend terms.
  always_comb begin
    b_d  = bt1_q + (64'(ap5_7_q) << 17) + (64'(cal_i.p4) << 35);
    a2_d = 64'($signed(aap3_q) >>> 8) + (64'(ap2_7_q) << 12);
    nb_d = ({43'b0, 21'(PressOne - {1'b0, rp8_q})} << 31) - b_q;
  end

  // Divisor from the scaled bias product, then magnitudes and quotient sign.
  always_comb begin
    dv          = prod_q[63:33];
    out_d.dz    = (dv == 31'd0);
    out_d.num   = nm_q[63] ? (64'd0 - nm_q) : nm_q;
    out_d.den   = dv[30] ? (31'd0 - dv) : dv;
    out_d.qneg  = nm_q[63] ^ dv[30];
    out_d.temp  = temp10_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= 26'(data_i.tfine - TfineOffset);
      temp5_q  <= temp5_d;
      rp5_q    <= data_i.raw_press;

      aa_q     <= a_q * a_q;
      ap5_q    <= a_q * cal_i.p5;
      ap2_q    <= a_q * cal_i.p2;
      temp6_q  <= temp5_q;
      rp6_q    <= rp5_q;

      bt1_q    <= mul_u64_s16(64'(aa_q), cal_i.p6);
      aap3_q   <= mul_u64_s16(64'(aa_q), cal_i.p3);
      ap5_7_q  <= ap5_q;
      ap2_7_q  <= ap2_q;
      temp7_q  <= temp6_q;
      rp7_q    <= rp6_q;

      b_q      <= b_d;
      a2_q     <= a2_d;
      temp8_q  <= temp7_q;
      rp8_q    <= rp7_q;

      x_q      <= PressBias + a2_q;
      nb_q     <= nb_d;
      temp9_q  <= temp8_q;

      prod_q   <= mul_u64_u16(x_q, cal_i.p1);
      nm_q     <= mul_u64_u16(nb_q, PressScale);
      temp10_q <= temp9_q;

      out_q    <= out_d;
    end
  end

  assign vld_o  = vld_q[6];
  assign data_o = out_q;

endmodule

/* rtl/bpc_div.sv */
// Restoring divider: one quotient bit per pipeline stage, 64 stages.
// Depends on bpc_pkg.
module bpc_div import bpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     vld_i,
  input  div_in_t  data_i,
  output logic     vld_o,
  output div_out_t data_o
);

  typedef struct packed {
    logic [30:0]        rem;
    logic [63:0]        nq;
    logic [30:0]        den;
    logic               qneg;
    logic               dz;
    logic signed [31:0] temp;
  } dstage_t;

  dstage_t             st_q [DivSteps];
  logic [DivSteps-1:0] vld_q;
  dstage_t             init;

  // The dividend enters the shift word; quotient bits fill it from the bottom.
  always_comb begin
    init.rem  = '0;
    init.nq   = data_i.num;
    init.den  = data_i.den;
    init.qneg = data_i.qneg;
    init.dz   = data_i.dz;
    init.temp = data_i.temp;
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    dstage_t     src;
    dstage_t     nxt;
    logic        src_vld;
    logic [31:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign src     = init;
      assign src_vld = vld_i;
    end else begin : g_next
      assign src     = st_q[i-1];
      assign src_vld = vld_q[i-1];
    end

    // Shift in one dividend bit and subtract the divisor where it fits.
    always_comb begin
      trial   = {src.rem, src.nq[63]};
      ge      = (trial >= {1'b0, src.den});
      nxt     = src;
      nxt.rem = ge ? 31'(trial - {1'b0, src.den}) : trial[30:0];
      nxt.nq  = {src.nq[62:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign vld_o       = vld_q[DivSteps-1];
  assign data_o.quo  = st_q[DivSteps-1].nq;
  assign data_o.qneg = st_q[DivSteps-1].qneg;
  assign data_o.dz   = st_q[DivSteps-1].dz;
  assign data_o.temp = st_q[DivSteps-1].temp;

endmodule

/* rtl/bpc_post.sv */
// Final section: six stages of correction terms, arithmetic shift and saturation.
// Depends on bpc_pkg.
module bpc_post import bpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     vld_i,
  input  div_out_t data_i,
  input  cal_t     cal_i,
  output logic     vld_o,
  output out_t     data_o
);

  logic [5:0]         vld_q;
  logic [63:0]        p1_q, p2_q, p3_q, p4_q;
  logic [63:0]        q13;
  logic [63:0]        ll_q;
  logic [31:0]        lh_q;
  logic [63:0]        v2p_q, v2p3_q, v2p4_q;
  logic [63:0]        qq_q;
  logic [63:0]        v1p_q;
  logic [63:0]        s_q, s_d;
  logic [63:0]        r;
  logic [31:0]        sat;
  logic               dz1_q, dz2_q, dz3_q, dz4_q, dz5_q;
  logic signed [31:0] tp1_q, tp2_q, tp3_q, tp4_q, tp5_q;
  out_t               out_q, out_d;

  // Square of p >> 13 modulo 2^64 from 32-bit halves.
  assign q13 = 64'($signed(p1_q) >>> 13);

  // Quotient plus the two correction terms.
  assign s_d = p4_q + 64'($signed(v1p_q) >>> 25) + 64'($signed(v2p4_q) >>> 19);

  // Final shift, offset and clamp to the unsigned 32-bit range.
  always_comb begin
    r = 64'($signed(s_q) >>> 8) + (64'(cal_i.p7) << 4);
    if (r[63]) begin
      sat = '0;
    end else if (r[63:32] != 32'd0) begin
      sat = '1;
    end else begin
      sat = r[31:0];
    end
    out_d.temp_centi  = tp5_q;
    out_d.press_q24_8 = dz5_q ? 32'd0 : sat;
    out_d.press_valid = ~dz5_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= data_i.qneg ? (64'd0 - data_i.quo) : data_i.quo;
      dz1_q  <= data_i.dz;
      tp1_q  <= data_i.temp;

      ll_q   <= 64'(q13[31:0]) * 64'(q13[31:0]);
      lh_q   <= q13[31:0] * q13[63:32];
      v2p_q  <= mul_u64_s16(p1_q, cal_i.p8);
      p2_q   <= p1_q;
      dz2_q  <= dz1_q;
      tp2_q  <= tp1_q;

      qq_q   <= ll_q + {lh_q[30:0], 33'b0};
      v2p3_q <= v2p_q;
      p3_q   <= p2_q;
      dz3_q  <= dz2_q;
      tp3_q  <= tp2_q;

      v1p_q  <= mul_u64_s16(qq_q, cal_i.p9);
      v2p4_q <= v2p3_q;
      p4_q   <= p3_q;
      dz4_q  <= dz3_q;
      tp4_q  <= tp3_q;

      s_q    <= s_d;
      dz5_q  <= dz4_q;
      tp5_q  <= tp4_q;

      out_q  <= out_d;
    end
  end

  assign vld_o  = vld_q[5];
  assign data_o = out_q;

endmodule

/* rtl/barometric_pressure_compensation_top.sv */
// From the accepting edge to the result register: 4 temperature, 7 coefficient, 64
// divider and 6 final stages, then the output register. The 64-stage restoring
// divider sets the depth. Throughput: one item per cycle while the skid is free.
// A two-entry output (register plus skid) takes one more item while a result waits.
// Reset clears all valid bits and the four trimming registers to zero.
// Depends on bpc_pkg, bpc_temp, bpc_coef, bpc_div and bpc_post.
module barometric_pressure_compensation_top import bpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  // Result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [RegW-1:0] cal_q [4];
  cal_t            cal;
  logic            cfg_we;
  logic [1:0]      cfg_idx;

  logic            en;
  logic            tv, cv, dv, pv;
  tf_t             td;
  div_in_t         cd;
  div_out_t        dd;
  out_t            pd;

  logic            out_vld_q, out_vld_d;
  logic            skid_vld_q, skid_vld_d;
  out_t            out_q, out_d, skid_q, skid_d;
  logic            out_fire, push;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:3];
  assign prdata  = {16'b0, cal_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q[RegCalTemp]   <= '0;
      cal_q[RegCalPressA] <= '0;
      cal_q[RegCalPressB] <= '0;
      cal_q[RegCalPressC] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegCalTemp:   cal_q[RegCalTemp]   <= pwdata[RegW-1:0];
        RegCalPressA: cal_q[RegCalPressA] <= pwdata[RegW-1:0];
        RegCalPressB: cal_q[RegCalPressB] <= pwdata[RegW-1:0];
        RegCalPressC: cal_q[RegCalPressC] <= pwdata[RegW-1:0];
        default:      ;
      endcase
    end
  end

  // Trimming words.
  assign cal.t1 = cal_q[RegCalTemp][15:0];
  assign cal.t2 = cal_q[RegCalTemp][31:16];
  assign cal.t3 = cal_q[RegCalTemp][47:32];
  assign cal.p1 = cal_q[RegCalPressA][15:0];
  assign cal.p2 = cal_q[RegCalPressA][31:16];
  assign cal.p3 = cal_q[RegCalPressA][47:32];
  assign cal.p4 = cal_q[RegCalPressB][15:0];
  assign cal.p5 = cal_q[RegCalPressB][31:16];
  assign cal.p6 = cal_q[RegCalPressB][47:32];
  assign cal.p7 = cal_q[RegCalPressC][15:0];
  assign cal.p8 = cal_q[RegCalPressC][31:16];
  assign cal.p9 = cal_q[RegCalPressC][47:32];

  // The pipeline advances whenever the skid entry is free.
  assign en         = ~skid_vld_q;
  assign in_ready_o = en;

  bpc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .data_i(in_data_i),
    .cal_i(cal), .vld_o(tv), .data_o(td)
  );

  bpc_coef u_coef (
    .clk_i, .rst_ni, .en_i(en), .vld_i(tv), .data_i(td),
    .cal_i(cal), .vld_o(cv), .data_o(cd)
  );

  bpc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cv), .data_i(cd),
    .vld_o(dv), .data_o(dd)
  );

  bpc_post u_post (
    .clk_i, .rst_ni, .en_i(en), .vld_i(dv), .data_i(dd),
    .cal_i(cal), .vld_o(pv), .data_o(pd)
  );

  // Output register with a skid entry behind it.
  assign out_fire = out_vld_q & out_ready_i;
  assign push     = en & pv;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_fire) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || out_fire) begin
        out_d     = pd;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = pd;
        skid_vld_d = 1'b1;
      end
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
